/* rtl/constrained_walk_count_dp_macros.svh */
// Assertion macros used by the checker of the constrained walk counter.
`ifndef CONSTRAINED_WALK_COUNT_DP_MACROS_SVH
`define CONSTRAINED_WALK_COUNT_DP_MACROS_SVH

// Implication that must hold in the same cycle.
`define CWC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Implication that must hold in the next cycle.
`define CWC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

/* rtl/cwc_pkg.sv */
// Package with widths, constants and interface structs of the constrained walk counter.
`timescale 1ns / 1ps

package cwc_pkg;

	// Field and store widths.
	localparam int WAYS_W = 30;
	localparam int VAL_W  = 8;
	localparam int DEPTH  = 128;
	localparam int ADDR_W = 7;
	localparam int STEP_W = 8;

	// Modulus of all counts.
	localparam logic [WAYS_W-1:0] PRIME = 30'd1000000007;

	// Register reset value and the saturation bound of the value range.
	localparam logic [VAL_W-1:0] MAX_RESET = 8'd100;
	localparam logic [VAL_W-1:0] MAX_BOUND = 8'd128;

	// Sweep step windows: read issue, pair add, entry write, total accumulate.
	localparam logic [STEP_W-1:0] S1_FIRST  = 8'd2;
	localparam logic [STEP_W-1:0] S1_LAST   = 8'd129;
	localparam logic [STEP_W-1:0] S2_FIRST  = 8'd3;
	localparam logic [STEP_W-1:0] S2_LAST   = 8'd130;
	localparam logic [STEP_W-1:0] S3_FIRST  = 8'd4;
	localparam logic [STEP_W-1:0] LAST_STEP = 8'd131;

	// One array position handed to the sweep engine.
	typedef struct packed {
		logic [VAL_W-1:0] fixed_val;
		logic             last;
		logic             first;
		logic [VAL_W-1:0] max_val;
	} cwc_job_t;

	// Status returned by the sweep engine.
	typedef struct packed {
		logic              busy;
		logic              emit;
		logic [WAYS_W-1:0] total;
	} cwc_stat_t;

endpackage

/* rtl/constrained_walk_count_dp.sv */
// Top level of the constrained walk counter: channels, configuration and result register.
//
//   Channel   Direction  Signals                          Transaction
//   cfg       in         cfg_we, cfg_wdata                one max_value write, no wait
//   in        in         in_valid/in_ready, fixed_value,  one array position
//                        is_last
//   out       out        out_valid/out_ready,             count of arrays, on last position
//                        total_count
//
// Each position runs a full sweep from acceptance to the next acceptance: the store read fills,
// every one of the 128 entries is visited, the adders drain, then come the done state and the
// idle state that raises ready again, whatever max_value is.
// A finished last position waits in the done cycle while the result register is still full.
// Reset clears the sequencer and the result valid flag, sets the start-of-array flag and loads
// max_value with 100; the store needs no clearing since the first position writes every entry.
`timescale 1ns / 1ps

module constrained_walk_count_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [cwc_pkg::VAL_W-1:0]  cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [cwc_pkg::VAL_W-1:0]  fixed_value,
	input  logic                       is_last,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [cwc_pkg::WAYS_W-1:0] total_count
);

	logic [cwc_pkg::VAL_W-1:0]  max_q;
	logic                       first_q;
	logic                       out_valid_q;
	logic [cwc_pkg::WAYS_W-1:0] total_q;
	logic                       in_acc;
	logic                       slot_free;
	cwc_pkg::cwc_job_t          job;
	cwc_pkg::cwc_stat_t         stat;

	assign in_ready  = !stat.busy;
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	// Job for the sweep engine, with max_value saturated to the store depth.
	always_comb begin
		job.fixed_val = fixed_value;
		job.last      = is_last;
		job.first     = first_q;
		job.max_val   = (max_q > cwc_pkg::MAX_BOUND) ? cwc_pkg::MAX_BOUND : max_q;
	end

	cwc_sweep u_sweep (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_acc),
		.job       (job),
		.slot_free (slot_free),
		.stat      (stat)
	);

	// Configuration register and start-of-array flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= cwc_pkg::MAX_RESET;
			first_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (in_acc) begin
				first_q <= is_last;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.emit) begin
			total_q <= stat.total;
		end
	end

	assign out_valid   = out_valid_q;
	assign total_count = total_q;

endmodule

/* rtl/cwc_modadd.sv */
// Modular adder: sum of two residues reduced by one conditional subtract.
`timescale 1ns / 1ps

module cwc_modadd (
	input  logic [cwc_pkg::WAYS_W-1:0] a,
	input  logic [cwc_pkg::WAYS_W-1:0] b,
	output logic [cwc_pkg::WAYS_W-1:0] sum
);

	logic [cwc_pkg::WAYS_W:0] raw;
	logic [cwc_pkg::WAYS_W:0] red;

	// Both operands are below the prime, so one subtract is enough.
	always_comb begin
		raw = {1'b0, a} + {1'b0, b};
		red = raw - {1'b0, cwc_pkg::PRIME};
		if (raw >= {1'b0, cwc_pkg::PRIME}) begin
			sum = red[cwc_pkg::WAYS_W-1:0];
		end else begin
			sum = raw[cwc_pkg::WAYS_W-1:0];
		end
	end

endmodule

/* rtl/cwc_store.sv */
// Count store: one write port and one registered read port.
`timescale 1ns / 1ps

module cwc_store (
	input  logic                       clk,
	input  logic                       we,
	input  logic [cwc_pkg::ADDR_W-1:0] waddr,
	input  logic [cwc_pkg::WAYS_W-1:0] wdata,
	input  logic [cwc_pkg::ADDR_W-1:0] raddr,
	output logic [cwc_pkg::WAYS_W-1:0] rdata
);

	logic [cwc_pkg::WAYS_W-1:0] mem_q [cwc_pkg::DEPTH];
	logic [cwc_pkg::WAYS_W-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/cwc_sweep.sv */
// Sweep engine: walks the count store once per position through three modular adders.
`timescale 1ns / 1ps

module cwc_sweep (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cwc_pkg::cwc_job_t job,
	input  logic              slot_free,
	output cwc_pkg::cwc_stat_t stat
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                 state_q;
	logic [cwc_pkg::STEP_W-1:0] step_q;
	cwc_pkg::cwc_job_t          job_q;

	logic [cwc_pkg::WAYS_W-1:0] rd_data;
	logic [cwc_pkg::WAYS_W-1:0] o_prev_q;
	logic [cwc_pkg::WAYS_W-1:0] o_cur_q;
	logic [cwc_pkg::WAYS_W-1:0] pair_s1;
	logic [cwc_pkg::WAYS_W-1:0] prev_s1;
	logic [cwc_pkg::ADDR_W-1:0] idx_s1;
	logic [cwc_pkg::WAYS_W-1:0] nxt_s2;
	logic [cwc_pkg::WAYS_W-1:0] total_q;

	logic                       run;
	logic                       st1;
	logic                       st2;
	logic                       st3;
	logic [cwc_pkg::STEP_W-1:0] idx1;
	logic [cwc_pkg::WAYS_W-1:0] nb_term;
	logic [cwc_pkg::WAYS_W-1:0] pair_sum;
	logic [cwc_pkg::WAYS_W-1:0] tri_sum;
	logic [cwc_pkg::WAYS_W-1:0] tot_sum;
	logic [cwc_pkg::VAL_W-1:0]  val2;
	logic                       keep2;
	logic [cwc_pkg::WAYS_W-1:0] nxt;

	// Stage windows over the sweep step.
	always_comb begin
		run  = (state_q == ST_RUN);
		st1  = run && (step_q >= cwc_pkg::S1_FIRST) && (step_q <= cwc_pkg::S1_LAST);
		st2  = run && (step_q >= cwc_pkg::S2_FIRST) && (step_q <= cwc_pkg::S2_LAST);
		st3  = run && (step_q >= cwc_pkg::S3_FIRST);
		idx1 = step_q - cwc_pkg::S1_FIRST;
	end

	// Stage one: the right neighbor counts only while its value stays in range.
	assign nb_term = (step_q <= job_q.max_val) ? rd_data : '0;

	cwc_modadd u_add_pair (
		.a   (o_cur_q),
		.b   (nb_term),
		.sum (pair_sum)
	);

	// Stage two: add the left neighbor and apply the position constraint.
	cwc_modadd u_add_tri (
		.a   (pair_s1),
		.b   (prev_s1),
		.sum (tri_sum)
	);

	always_comb begin
		val2  = {1'b0, idx_s1} + 8'd1;
		keep2 = (val2 <= job_q.max_val) &&
			((job_q.fixed_val == '0) || (job_q.fixed_val == val2));
		if (!keep2) begin
			nxt = '0;
		end else if (job_q.first) begin
			nxt = {{(cwc_pkg::WAYS_W-1){1'b0}}, 1'b1};
		end else begin
			nxt = tri_sum;
		end
	end

	cwc_store u_store (
		.clk   (clk),
		.we    (st2),
		.waddr (idx_s1),
		.wdata (nxt),
		.raddr (step_q[cwc_pkg::ADDR_W-1:0]),
		.rdata (rd_data)
	);

	// Stage three: running total of the new counts.
	cwc_modadd u_add_total (
		.a   (total_q),
		.b   (nxt_s2),
		.sum (tot_sum)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 8'd1;
					if (step_q == cwc_pkg::LAST_STEP) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!job_q.last || slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Job capture and datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			job_q   <= job;
			total_q <= '0;
		end
		if (run) begin
			o_prev_q <= o_cur_q;
			o_cur_q  <= rd_data;
		end
		if (st1) begin
			pair_s1 <= pair_sum;
			prev_s1 <= (step_q >= cwc_pkg::S2_FIRST) ? o_prev_q : '0;
			idx_s1  <= idx1[cwc_pkg::ADDR_W-1:0];
		end
		if (st2) begin
			nxt_s2 <= nxt;
		end
		if (st3) begin
			total_q <= tot_sum;
		end
	end

	// Status toward the channel logic.
	always_comb begin
		stat.busy  = (state_q != ST_IDLE);
		stat.emit  = (state_q == ST_DONE) && job_q.last && slot_free;
		stat.total = total_q;
	end

endmodule

/* rtl/cwc_checker.sv */
// Port-level checker for the constrained walk counter, bound to the top level.
`timescale 1ns / 1ps
`include "constrained_walk_count_dp_macros.svh"

module cwc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cfg_we,
	input logic [cwc_pkg::VAL_W-1:0]  cfg_wdata,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic [cwc_pkg::VAL_W-1:0]  fixed_value,
	input logic                       is_last,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [cwc_pkg::WAYS_W-1:0] total_count
);

	// A stalled result stays offered and unchanged.
	`CWC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`CWC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(total_count), "result changed while stalled")

	// A position keeps the block busy for the whole sweep.
	`CWC_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "input taken during a sweep")

	// Every count is a residue of the prime.
	`CWC_ASSERT_NOW(a_residue, out_valid, total_count < cwc_pkg::PRIME, "count not reduced")

	// A position that is not last yields no result right away.
	`CWC_ASSERT_NEXT(a_no_early, in_valid && in_ready && !is_last && !out_valid, !out_valid, "unexpected result")

endmodule

bind constrained_walk_count_dp cwc_checker u_cwc_checker (.*);
